// File: sv/blgc_pkg.sv
// Shared types, constants and table builders for the BGR to Lab b / gray / Cb converter.
// Used by the converter top level and by its port checker; depends on nothing else.
package blgc_pkg;

  // Fixed-point formats of the colour path.
  localparam int GAMMA_FRAC_BITS = 3;
  localparam int MIX_SHIFT       = 12;
  localparam int CURVE_FRAC_BITS = 15;
  localparam int CURVE_DEPTH     = 3072;

  // Linear light is scaled by 255 << GAMMA_FRAC_BITS.
  localparam int GSCALE  = 255 << GAMMA_FRAC_BITS;
  localparam int GAMMA_W = $clog2(GSCALE + 1);
  localparam int CURVE_W = 16;
  localparam int CURVE_AW = $clog2(CURVE_DEPTH);

  // Mixing coefficients and their product and sum widths.
  localparam int COEF_W = MIX_SHIFT + 1;
  localparam int PROD_W = GAMMA_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SUM_XW = SUM_W + 1;
  localparam int IDX_FULL_W = SUM_XW - MIX_SHIFT;

  // Gray and Cb widths.
  localparam int LUMA_PROD_W = 24;
  localparam int LUMA_SUM_W  = 26;
  localparam int DIFF_W      = 27;
  localparam int CBP_W       = 44;
  localparam int CBV_W       = 45;

  // Lab b combine width: 200 times a 17-bit signed difference, plus rounding.
  localparam int LAB_W = CURVE_W + 1 + 8 + 1;

  // Cycles from an accepted item to its result strobe.
  localparam int PIPE_LATENCY = 5;

  // Configuration register indices and reset values.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_WEIGHT_RED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_WEIGHT_GREEN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_WEIGHT_BLUE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_BLUE_GAIN  = 8'd3;

  localparam logic [15:0] RST_GRAY_WEIGHT_RED   = 16'd19595;
  localparam logic [15:0] RST_GRAY_WEIGHT_GREEN = 16'd38470;
  localparam logic [15:0] RST_GRAY_WEIGHT_BLUE  = 16'd7471;
  localparam logic [15:0] RST_CHROMA_BLUE_GAIN  = 16'd36962;

  // D65 rows for Y and Z, scaled by 2^MIX_SHIFT and rounded half up.
  localparam logic [63:0] MIX_ONE   = 64'd1 << MIX_SHIFT;
  localparam logic [63:0] CY_R_WIDE = (64'd2 * 64'd212671 * MIX_ONE + 64'd1000000) / 64'd2000000;
  localparam logic [63:0] CY_G_WIDE = (64'd2 * 64'd715160 * MIX_ONE + 64'd1000000) / 64'd2000000;
  localparam logic [63:0] CY_B_WIDE = (64'd2 * 64'd72169 * MIX_ONE + 64'd1000000) / 64'd2000000;
  localparam logic [63:0] CZ_R_WIDE = (64'd2 * 64'd19334 * MIX_ONE + 64'd1088754) / 64'd2177508;
  localparam logic [63:0] CZ_G_WIDE = (64'd2 * 64'd119193 * MIX_ONE + 64'd1088754) / 64'd2177508;
  localparam logic [63:0] CZ_B_WIDE = (64'd2 * 64'd950227 * MIX_ONE + 64'd1088754) / 64'd2177508;

  localparam logic [COEF_W-1:0] CY_R = CY_R_WIDE[COEF_W-1:0];
  localparam logic [COEF_W-1:0] CY_G = CY_G_WIDE[COEF_W-1:0];
  localparam logic [COEF_W-1:0] CY_B = CY_B_WIDE[COEF_W-1:0];
  localparam logic [COEF_W-1:0] CZ_R = CZ_R_WIDE[COEF_W-1:0];
  localparam logic [COEF_W-1:0] CZ_G = CZ_G_WIDE[COEF_W-1:0];
  localparam logic [COEF_W-1:0] CZ_B = CZ_B_WIDE[COEF_W-1:0];

  // Half step used to round the mixed sum to a curve index.
  localparam logic [SUM_W:0] MIX_HALF = SUM_XW'(1) << (MIX_SHIFT - 1);

  // Denominator of the linear segment of the Lab curve.
  localparam logic [63:0] CURVE_DEN = 64'd29000 * 64'(GSCALE);

  // Width of the exact products used while building the gamma table.
  localparam int BIG_W = 320;

  // Item payloads.
  typedef struct packed {
    logic [7:0] chan_blue;
    logic [7:0] chan_green;
    logic [7:0] chan_red;
    logic       frame_end;
  } blgc_in_t;

  typedef struct packed {
    logic [7:0] lab_b;
    logic [7:0] gray;
    logic [7:0] chroma_blue;
    logic       frame_done;
  } blgc_out_t;

  // Table types.
  typedef logic [255:0][GAMMA_W-1:0]         gamma_rom_t;
  typedef logic [CURVE_DEPTH-1:0][CURVE_W-1:0] curve_rom_t;

  // sRGB linearisation table. Above the knee the entry is the largest n with
  // n^5 * 269025^12 <= G^5 * (1000i + 14025)^12, found by bisection on exact products.
  function automatic gamma_rom_t build_gamma_rom();
    gamma_rom_t          rom;
    logic [BIG_W-1:0]    base_b12;
    logic [BIG_W-1:0]    rhs;
    logic [BIG_W-1:0]    lhs;
    logic [BIG_W-1:0]    a_big;
    logic [GAMMA_W:0]    lo;
    logic [GAMMA_W:0]    hi;
    logic [GAMMA_W:0]    mid;
    base_b12 = BIG_W'(1);
    for (int k = 0; k < 12; k++) begin
      base_b12 = base_b12 * BIG_W'(269025);
    end
    for (int i = 0; i < 256; i++) begin
      if (i * 100000 <= 4045 * 255) begin
        rom[i[7:0]] = GAMMA_W'(((i << GAMMA_FRAC_BITS) * 100) / 1292);
      end else begin
        a_big = BIG_W'(1000 * i + 14025);
        rhs   = BIG_W'(1);
        for (int k = 0; k < 12; k++) begin
          rhs = rhs * a_big;
        end
        for (int k = 0; k < 5; k++) begin
          rhs = rhs * BIG_W'(GSCALE);
        end
        lo = '0;
        hi = (GAMMA_W + 1)'(GSCALE);
        for (int s = 0; s < GAMMA_W + 2; s++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 1'b1) >> 1);
            lhs = base_b12;
            for (int k = 0; k < 5; k++) begin
              lhs = lhs * BIG_W'(mid);
            end
            if (lhs <= rhs) begin
              lo = mid;
            end else begin
              hi = mid - 1'b1;
            end
          end
        end
        rom[i[7:0]] = lo[GAMMA_W-1:0];
      end
    end
    return rom;
  endfunction

  // Lab f(t) table: linear segment below the threshold, floor of the cube root above it.
  function automatic curve_rom_t build_curve_rom();
    curve_rom_t  rom;
    logic [63:0] iv;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int i = 0; i < CURVE_DEPTH; i++) begin
      iv = 64'(i);
      if (iv * 64'd1000000 < 64'd8856 * 64'(GSCALE)) begin
        num = (iv * 64'd225823 + 64'd4000 * 64'(GSCALE)) << CURVE_FRAC_BITS;
        quo = num / CURVE_DEN;
        rom[i[CURVE_AW-1:0]] = (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
      end else begin
        target = iv << (3 * CURVE_FRAC_BITS);
        lo = 64'd0;
        hi = 64'd65535;
        for (int s = 0; s < 17; s++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (mid * mid * mid * 64'(GSCALE) <= target) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        rom[i[CURVE_AW-1:0]] = lo[15:0];
      end
    end
    return rom;
  endfunction

  // Round a mixed sum to a curve index and clamp it to the last table entry.
  function automatic logic [CURVE_AW-1:0] curve_index(input logic [SUM_W-1:0] sum);
    logic [SUM_W:0]          rounded;
    logic [IDX_FULL_W-1:0]   idx_full;
    logic [CURVE_AW-1:0]     idx;
    rounded  = {1'b0, sum} + MIX_HALF;
    idx_full = rounded[SUM_W:MIX_SHIFT];
    if (32'(idx_full) > 32'(CURVE_DEPTH - 1)) begin
      idx = CURVE_AW'(CURVE_DEPTH - 1);
    end else begin
      idx = CURVE_AW'(idx_full);
    end
    return idx;
  endfunction

endpackage

// File: sv/bgr_to_lab_b_gray_cb.sv
// Top level of the pixel converter: BGR bytes in, Lab b, gray and Cb bytes out.
// Depends on blgc_pkg for payload types, formats and the two table builders.
//
// Usage
//   Input: present a pixel on in_data and raise start; the item is taken at
//   a rising edge where start is high and busy is low. busy is high only
//   while rst_n is low, so after reset one pixel can be taken every cycle.
//   Output: each result appears on out_data for exactly one cycle with
//   out_strobe high, when its pixel leaves the last stage. Results leave in
//   the order the pixels came in. The receiver cannot stall the block, and
//   nothing inside ever waits, so throughput is one pixel per clock.
//   The five stages are: gamma table and gray products, mixing products and
//   luma sum, curve index and Cb difference, curve table read (registered,
//   two read ports) and Cb gain product, then the Lab b and Cb combine.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data write
//   the gray weights (index 0 to 2) and the Cb gain (index 3); other indices
//   are ignored. cfg_ready is always high. Write only while no item is in
//   flight.
//   Reset (synchronous, rst_n low) empties the pipeline and restores the
//   default weights and Cb gain; both tables are constant and need no loading.
module bgr_to_lab_b_gray_cb (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  blgc_pkg::blgc_in_t                 in_data,
  output logic                               out_strobe,
  output blgc_pkg::blgc_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);

  localparam int GAMMA_W  = blgc_pkg::GAMMA_W;
  localparam int PROD_W   = blgc_pkg::PROD_W;
  localparam int SUM_W    = blgc_pkg::SUM_W;
  localparam int CURVE_W  = blgc_pkg::CURVE_W;
  localparam int CURVE_AW = blgc_pkg::CURVE_AW;
  localparam int LP_W     = blgc_pkg::LUMA_PROD_W;
  localparam int LS_W     = blgc_pkg::LUMA_SUM_W;
  localparam int DIFF_W   = blgc_pkg::DIFF_W;
  localparam int CBP_W    = blgc_pkg::CBP_W;
  localparam int CBV_W    = blgc_pkg::CBV_W;
  localparam int LAB_W    = blgc_pkg::LAB_W;
  localparam int CFB      = blgc_pkg::CURVE_FRAC_BITS;

  localparam blgc_pkg::gamma_rom_t GAMMA_ROM = blgc_pkg::build_gamma_rom();
  localparam blgc_pkg::curve_rom_t CURVE_ROM = blgc_pkg::build_curve_rom();

  localparam logic signed [LAB_W-1:0] LAB_MUL = LAB_W'(200);
  localparam logic signed [LAB_W-1:0] LAB_RND = LAB_W'(1) << (CFB - 1);
  localparam logic [7:0]              LAB_OFFSET = 8'd128;
  localparam logic signed [CBV_W-1:0] CB_BIAS = CBV_W'(128) << 32;

  // Handshakes: the pipeline never stalls, so only reset holds items off.
  logic in_accept;
  logic cfg_write;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign in_accept = start & ~busy;
  assign cfg_write = cfg_valid & cfg_ready;

  // Configuration registers.
  logic [15:0] weight_red_r, weight_red_nxt;
  logic [15:0] weight_green_r, weight_green_nxt;
  logic [15:0] weight_blue_r, weight_blue_nxt;
  logic [15:0] cb_gain_r, cb_gain_nxt;

  always_comb begin
    weight_red_nxt   = weight_red_r;
    weight_green_nxt = weight_green_r;
    weight_blue_nxt  = weight_blue_r;
    cb_gain_nxt      = cb_gain_r;
    if (cfg_write) begin
      case (cfg_index)
        blgc_pkg::CFG_GRAY_WEIGHT_RED:   weight_red_nxt   = cfg_data;
        blgc_pkg::CFG_GRAY_WEIGHT_GREEN: weight_green_nxt = cfg_data;
        blgc_pkg::CFG_GRAY_WEIGHT_BLUE:  weight_blue_nxt  = cfg_data;
        blgc_pkg::CFG_CHROMA_BLUE_GAIN:  cb_gain_nxt      = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_red_r   <= blgc_pkg::RST_GRAY_WEIGHT_RED;
      weight_green_r <= blgc_pkg::RST_GRAY_WEIGHT_GREEN;
      weight_blue_r  <= blgc_pkg::RST_GRAY_WEIGHT_BLUE;
      cb_gain_r      <= blgc_pkg::RST_CHROMA_BLUE_GAIN;
    end else begin
      weight_red_r   <= weight_red_nxt;
      weight_green_r <= weight_green_nxt;
      weight_blue_r  <= weight_blue_nxt;
      cb_gain_r      <= cb_gain_nxt;
    end
  end

  // Valid bits, one per stage, travelling with the data.
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // Stage 1: linearise each channel and form the weighted gray products.
  logic [GAMMA_W-1:0] s1_lin_red_nxt, s1_lin_green_nxt, s1_lin_blue_nxt;
  logic [GAMMA_W-1:0] s1_lin_red_r, s1_lin_green_r, s1_lin_blue_r;
  logic [LP_W-1:0]    s1_luma_red_nxt, s1_luma_green_nxt, s1_luma_blue_nxt;
  logic [LP_W-1:0]    s1_luma_red_r, s1_luma_green_r, s1_luma_blue_r;
  logic [7:0]         s1_blue_r;
  logic               s1_frame_r;

  always_comb begin
    s1_lin_red_nxt    = GAMMA_ROM[in_data.chan_red];
    s1_lin_green_nxt  = GAMMA_ROM[in_data.chan_green];
    s1_lin_blue_nxt   = GAMMA_ROM[in_data.chan_blue];
    s1_luma_red_nxt   = LP_W'(in_data.chan_red) * LP_W'(weight_red_r);
    s1_luma_green_nxt = LP_W'(in_data.chan_green) * LP_W'(weight_green_r);
    s1_luma_blue_nxt  = LP_W'(in_data.chan_blue) * LP_W'(weight_blue_r);
  end

  always_ff @(posedge clk) begin
    s1_lin_red_r    <= s1_lin_red_nxt;
    s1_lin_green_r  <= s1_lin_green_nxt;
    s1_lin_blue_r   <= s1_lin_blue_nxt;
    s1_luma_red_r   <= s1_luma_red_nxt;
    s1_luma_green_r <= s1_luma_green_nxt;
    s1_luma_blue_r  <= s1_luma_blue_nxt;
    s1_blue_r       <= in_data.chan_blue;
    s1_frame_r      <= in_data.frame_end;
  end

  // Stage 2: the six Y and Z mixing products, and the full luma sum.
  logic [PROD_W-1:0] s2_y_red_nxt, s2_y_green_nxt, s2_y_blue_nxt;
  logic [PROD_W-1:0] s2_z_red_nxt, s2_z_green_nxt, s2_z_blue_nxt;
  logic [PROD_W-1:0] s2_y_red_r, s2_y_green_r, s2_y_blue_r;
  logic [PROD_W-1:0] s2_z_red_r, s2_z_green_r, s2_z_blue_r;
  logic [LS_W-1:0]   s2_luma_nxt, s2_luma_r;
  logic [7:0]        s2_blue_r;
  logic              s2_frame_r;

  always_comb begin
    s2_y_red_nxt   = PROD_W'(s1_lin_red_r)   * PROD_W'(blgc_pkg::CY_R);
    s2_y_green_nxt = PROD_W'(s1_lin_green_r) * PROD_W'(blgc_pkg::CY_G);
    s2_y_blue_nxt  = PROD_W'(s1_lin_blue_r)  * PROD_W'(blgc_pkg::CY_B);
    s2_z_red_nxt   = PROD_W'(s1_lin_red_r)   * PROD_W'(blgc_pkg::CZ_R);
    s2_z_green_nxt = PROD_W'(s1_lin_green_r) * PROD_W'(blgc_pkg::CZ_G);
    s2_z_blue_nxt  = PROD_W'(s1_lin_blue_r)  * PROD_W'(blgc_pkg::CZ_B);
    s2_luma_nxt    = LS_W'(s1_luma_red_r) + LS_W'(s1_luma_green_r) + LS_W'(s1_luma_blue_r);
  end

  always_ff @(posedge clk) begin
    s2_y_red_r   <= s2_y_red_nxt;
    s2_y_green_r <= s2_y_green_nxt;
    s2_y_blue_r  <= s2_y_blue_nxt;
    s2_z_red_r   <= s2_z_red_nxt;
    s2_z_green_r <= s2_z_green_nxt;
    s2_z_blue_r  <= s2_z_blue_nxt;
    s2_luma_r    <= s2_luma_nxt;
    s2_blue_r    <= s1_blue_r;
    s2_frame_r   <= s1_frame_r;
  end

  // Stage 3: sum and round Y and Z into curve indices; saturate gray and
  // form blue minus the unrounded luma for Cb.
  logic [CURVE_AW-1:0]      s3_idx_y_nxt, s3_idx_z_nxt, s3_idx_y_r, s3_idx_z_r;
  logic [7:0]               s3_gray_nxt, s3_gray_r;
  logic signed [DIFF_W-1:0] s3_diff_nxt, s3_diff_r;
  logic                     s3_frame_r;

  always_comb begin
    s3_idx_y_nxt = blgc_pkg::curve_index(SUM_W'(s2_y_red_r) + SUM_W'(s2_y_green_r)
                                         + SUM_W'(s2_y_blue_r));
    s3_idx_z_nxt = blgc_pkg::curve_index(SUM_W'(s2_z_red_r) + SUM_W'(s2_z_green_r)
                                         + SUM_W'(s2_z_blue_r));
    if (|s2_luma_r[LS_W-1:24]) begin
      s3_gray_nxt = 8'hFF;
    end else begin
      s3_gray_nxt = s2_luma_r[23:16];
    end
    s3_diff_nxt = $signed({3'b000, s2_blue_r, 16'h0000}) - $signed({1'b0, s2_luma_r});
  end

  always_ff @(posedge clk) begin
    s3_idx_y_r <= s3_idx_y_nxt;
    s3_idx_z_r <= s3_idx_z_nxt;
    s3_gray_r  <= s3_gray_nxt;
    s3_diff_r  <= s3_diff_nxt;
    s3_frame_r <= s2_frame_r;
  end

  // Stage 4: registered reads of the curve table at both indices, and the
  // Cb gain product.
  logic [CURVE_W-1:0]      s4_fy_r, s4_fz_r;
  logic signed [CBP_W-1:0] s4_cbp_nxt, s4_cbp_r;
  logic [7:0]              s4_gray_r;
  logic                    s4_frame_r;

  always_comb begin
    s4_cbp_nxt = CBP_W'(s3_diff_r) * CBP_W'($signed({1'b0, cb_gain_r}));
  end

  always_ff @(posedge clk) begin
    s4_fy_r    <= CURVE_ROM[s3_idx_y_r];
    s4_fz_r    <= CURVE_ROM[s3_idx_z_r];
    s4_cbp_r   <= s4_cbp_nxt;
    s4_gray_r  <= s3_gray_r;
    s4_frame_r <= s3_frame_r;
  end

  // Stage 5: Lab b is 200 * (fY - fZ) rounded and floored to whole units,
  // offset by 128 and kept modulo 256; Cb is biased and clamped to a byte.
  logic signed [CURVE_W:0]  lab_diff;
  logic signed [LAB_W-1:0]  lab_sum;
  logic signed [CBV_W-1:0]  cb_val;
  blgc_pkg::blgc_out_t      out_nxt, out_r;

  always_comb begin
    lab_diff = $signed({1'b0, s4_fy_r}) - $signed({1'b0, s4_fz_r});
    lab_sum  = LAB_W'(lab_diff) * LAB_MUL + LAB_RND;
    cb_val   = CBV_W'(s4_cbp_r) + CB_BIAS;

    out_nxt.lab_b = lab_sum[CFB+7:CFB] + LAB_OFFSET;
    out_nxt.gray  = s4_gray_r;
    if (cb_val[CBV_W-1]) begin
      out_nxt.chroma_blue = 8'h00;
    end else if (|cb_val[CBV_W-2:40]) begin
      out_nxt.chroma_blue = 8'hFF;
    end else begin
      out_nxt.chroma_blue = cb_val[39:32];
    end
    out_nxt.frame_done = s4_frame_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

endmodule

// File: sv/blgc_checker.sv
// Port-level checker for the pixel converter, bound to its top level.
// Depends on blgc_pkg for the payload types and the pipeline latency.
module blgc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input blgc_pkg::blgc_in_t   in_data,
  input logic                 out_strobe,
  input blgc_pkg::blgc_out_t  out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  // Every item taken gives a strobe a fixed number of cycles later.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(blgc_pkg::PIPE_LATENCY) out_strobe)
    else $error("item taken without a result at the expected cycle");

  // No strobe appears without an item taken at the matching cycle.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, blgc_pkg::PIPE_LATENCY))
    else $error("result strobe without a matching item");

  // The frame marker travels with its own pixel.
  a_frame_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.frame_done == $past(in_data.frame_end, blgc_pkg::PIPE_LATENCY)))
    else $error("frame marker does not match its pixel");

  // The configuration port never holds a write off.
  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind bgr_to_lab_b_gray_cb blgc_checker u_blgc_checker (.*);
